/* rtl/core/shs_pkg.sv */
`default_nettype none
package shs_pkg;

  // fingerprint layout, byte 0 in the top bits of hi
  localparam int unsigned HI_W  = 64;
  localparam int unsigned MID_W = 64;
  localparam int unsigned LO_W  = 32;
  localparam int unsigned FP_W  = HI_W + MID_W + LO_W;

  // leading bits of the fingerprint that take part in the zero test
  localparam int unsigned FP_BITS = 160;

  localparam int unsigned ZC_W    = 7;
  localparam int unsigned CHUNK_W = 32;

  // register indexes
  localparam logic REG_SEGMENT = 1'b0;
  localparam logic REG_SAMPLE  = 1'b1;

  localparam logic [ZC_W-1:0] SEGMENT_RESET = 7'd11;
  localparam logic [ZC_W-1:0] SAMPLE_RESET  = 7'd8;

  // item kinds
  localparam logic [1:0] KIND_CHUNK      = 2'd0;
  localparam logic [1:0] KIND_STREAM_END = 2'd1;

  typedef struct packed {
    logic [HI_W-1:0]  hi;
    logic [MID_W-1:0] mid;
    logic [LO_W-1:0]  lo;
  } fp_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic segment;
    logic sample;
  } zero_hit_t;

  // top min(n, FP_BITS) bits of the packed fingerprint set
  function automatic logic [FP_W-1:0] zero_mask(input logic [ZC_W-1:0] n);
    logic [FP_W-1:0] m;
    m = '0;
    for (int j = 0; j < FP_W; j++) begin
      if ((j < int'(n)) && (j < FP_BITS)) begin
        m[FP_W-1-j] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/segment_hook_sampler.sv */
// channel  | direction | handshake           | payload
// input    | in        | in_valid / in_stall | kind, hash_hi, hash_mid, hash_lo
// result   | out       | out_valid/out_stall | hook_hi, hook_mid, hook_lo, segment_hooks,
//          |           |                     | segment_chunks, last_hook, hooks_dropped
// config   | in        | wr_en               | wr_index, wr_data
//
// an item that ends no held segment is taken without a stall; a boundary over
// held hooks keeps in_stall high until its last hook is taken, as the hooks leave
// one per cycle while out_stall is low, from the head of the cell row.
// hooks sit in a row of MAX_HOOKS cells that shifts toward cell 0 on a drain.
// reset is synchronous and clears counts, flag and state; cells hold no reset.
`default_nettype none
module segment_hook_sampler #(
  parameter int unsigned MAX_HOOKS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  kind,
  input  wire logic [shs_pkg::HI_W-1:0]    hash_hi,
  input  wire logic [shs_pkg::MID_W-1:0]   hash_mid,
  input  wire logic [shs_pkg::LO_W-1:0]    hash_lo,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [shs_pkg::HI_W-1:0]         hook_hi,
  output logic [shs_pkg::MID_W-1:0]        hook_mid,
  output logic [shs_pkg::LO_W-1:0]         hook_lo,
  output logic [shs_pkg::ZC_W-1:0]         segment_hooks,
  output logic [shs_pkg::CHUNK_W-1:0]      segment_chunks,
  output logic                             last_hook,
  output logic                             hooks_dropped,
  input  wire logic                        wr_en,
  input  wire logic                        wr_index,
  input  wire logic [shs_pkg::ZC_W-1:0]    wr_data
);

  localparam int unsigned CW = $clog2(MAX_HOOKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                       state;
  logic [CW-1:0]                hook_total;
  logic [CW-1:0]                remaining;
  logic [shs_pkg::CHUNK_W-1:0]  chunk_tally;
  logic                         drop_flag;
  logic                         pend_chunk;
  logic                         pend_hook;
  shs_pkg::fp_t                 pend_fp;

  shs_pkg::fp_t                 in_fp;
  shs_pkg::fp_t                 load_fp;
  shs_pkg::zero_hit_t           hit;
  shs_pkg::fp_t                 cell_fp [MAX_HOOKS];
  shs_pkg::cell_ctl_t           cell_ctl [MAX_HOOKS];

  logic in_take;
  logic out_take;
  logic is_chunk;
  logic boundary;
  logic start_drain;
  logic store_en;
  logic drain_done;
  logic [shs_pkg::CHUNK_W-1:0] tally_inc;

  assign in_fp = '{hi: hash_hi, mid: hash_mid, lo: hash_lo};

  shs_zero_test u_zero (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .fp       (in_fp),
    .hit      (hit)
  );

  // request decode
  assign in_stall    = (state == ST_DRAIN);
  assign in_take     = in_valid && !in_stall;
  assign out_valid   = (state == ST_DRAIN);
  assign out_take    = out_valid && !out_stall;
  assign is_chunk    = (kind == shs_pkg::KIND_CHUNK);
  assign boundary    = (kind == shs_pkg::KIND_STREAM_END) || (is_chunk && hit.segment);
  assign start_drain = in_take && boundary && (hook_total != '0);
  assign store_en    = in_take && !start_drain && is_chunk && hit.sample
                       && (hook_total < CW'(MAX_HOOKS));
  assign drain_done  = out_take && last_hook;
  assign tally_inc   = (chunk_tally == '1) ? chunk_tally : chunk_tally + 1'b1;

  // hook cell row
  assign load_fp = (state == ST_DRAIN) ? pend_fp : in_fp;

  for (genvar i = 0; i < MAX_HOOKS; i++) begin : g_cell
    shs_pkg::fp_t next_fp;

    if (i == MAX_HOOKS - 1) begin : g_tail
      assign next_fp = '0;
    end else begin : g_link
      assign next_fp = cell_fp[i+1];
    end

    assign cell_ctl[i].shift = out_take;
    if (i == 0) begin : g_head
      assign cell_ctl[i].load = (store_en && (hook_total == '0))
                                || (drain_done && pend_hook);
    end else begin : g_body
      assign cell_ctl[i].load = store_en && (hook_total == CW'(i));
    end

    shs_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .load_fp (load_fp),
      .next_fp (next_fp),
      .fp      (cell_fp[i])
    );
  end

  // segment control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      hook_total  <= '0;
      remaining   <= '0;
      chunk_tally <= '0;
      drop_flag   <= 1'b0;
      pend_chunk  <= 1'b0;
      pend_hook   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start_drain) begin
            state      <= ST_DRAIN;
            remaining  <= hook_total;
            pend_chunk <= is_chunk;
            pend_hook  <= is_chunk && hit.sample;
          end else if (in_take && is_chunk) begin
            chunk_tally <= tally_inc;
            if (hit.sample) begin
              if (hook_total < CW'(MAX_HOOKS)) begin
                hook_total <= hook_total + 1'b1;
              end else begin
                drop_flag <= 1'b1;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (out_take) begin
            remaining <= remaining - 1'b1;
          end
          if (drain_done) begin
            state       <= ST_IDLE;
            hook_total  <= pend_hook ? CW'(1) : '0;
            chunk_tally <= pend_chunk ? shs_pkg::CHUNK_W'(1) : '0;
            drop_flag   <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // boundary chunk waits here while its segment drains
  always_ff @(posedge clk) begin
    if (start_drain) begin
      pend_fp <= in_fp;
    end
  end

  // result fields
  assign hook_hi        = cell_fp[0].hi;
  assign hook_mid       = cell_fp[0].mid;
  assign hook_lo        = cell_fp[0].lo;
  assign segment_hooks  = shs_pkg::ZC_W'(hook_total);
  assign segment_chunks = chunk_tally;
  assign last_hook      = (remaining == CW'(1));
  assign hooks_dropped  = drop_flag;

endmodule
`default_nettype wire

/* rtl/core/shs_zero_test.sv */
`default_nettype none
module shs_zero_test (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic                     wr_index,
  input  wire logic [shs_pkg::ZC_W-1:0] wr_data,
  input  wire shs_pkg::fp_t             fp,
  output shs_pkg::zero_hit_t            hit
);

  logic [shs_pkg::FP_W-1:0] segment_mask;
  logic [shs_pkg::FP_W-1:0] sample_mask;
  logic [shs_pkg::FP_W-1:0] wr_mask;

  // thresholds are kept as masks, decoded when written
  assign wr_mask = shs_pkg::zero_mask(wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_mask <= shs_pkg::zero_mask(shs_pkg::SEGMENT_RESET);
      sample_mask  <= shs_pkg::zero_mask(shs_pkg::SAMPLE_RESET);
    end else if (wr_en) begin
      if (wr_index == shs_pkg::REG_SEGMENT) begin
        segment_mask <= wr_mask;
      end
      if (wr_index == shs_pkg::REG_SAMPLE) begin
        sample_mask <= wr_mask;
      end
    end
  end

  // all masked bits zero
  assign hit.segment = ~|(fp & segment_mask);
  assign hit.sample  = ~|(fp & sample_mask);

endmodule
`default_nettype wire

/* rtl/core/shs_cell.sv */
`default_nettype none
module shs_cell (
  input  wire logic               clk,
  input  wire shs_pkg::cell_ctl_t ctl,
  input  wire shs_pkg::fp_t       load_fp,
  input  wire shs_pkg::fp_t       next_fp,
  output shs_pkg::fp_t            fp
);

  // a load wins over a shift from the neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fp <= load_fp;
    end else if (ctl.shift) begin
      fp <= next_fp;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/shs_checker.sv */
`default_nettype none
module shs_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [shs_pkg::HI_W-1:0]  hook_hi,
  input wire logic [shs_pkg::ZC_W-1:0]  segment_hooks,
  input wire logic [shs_pkg::CHUNK_W-1:0] segment_chunks,
  input wire logic                      last_hook
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hook_hi) && $stable(last_hook))
    else $error("stalled result changed");

  // no request taken while a segment drains
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during drain");

  // a segment continues until its last hook
  a_segment_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_hook |=> out_valid
      && $stable(segment_hooks) && $stable(segment_chunks))
    else $error("segment broken before last hook");

  // every emitted segment holds a hook
  a_hooks_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> segment_hooks != '0)
    else $error("empty segment emitted");

endmodule

bind segment_hook_sampler shs_checker u_shs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .hook_hi        (hook_hi),
  .segment_hooks  (segment_hooks),
  .segment_chunks (segment_chunks),
  .last_hook      (last_hook)
);
`default_nettype wire
